// File: design/assert_macros.svh
// Assertion macros used by corner_track_extrapolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/cte_pkg.sv
package cte_pkg;

   localparam int COORD_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int GUARD             = 8;
   localparam int GAIN_WIDTH        = 8;
   localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 8'd192;
   // Vector datapath width: coordinates plus carry, guard and CORDIC growth.
   localparam int VEC_WIDTH = 32 + GUARD + 4;
   // Length datapath width for the extrapolated length and the rotation.
   localparam int LEN_WIDTH = 32 + GUARD + 6;

   typedef struct packed {
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] middle_x;
      logic signed [15:0] middle_y;
      logic signed [15:0] latest_x;
      logic signed [15:0] latest_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] predicted_x;
      logic signed [15:0] predicted_y;
      logic               clipped;
   } rsp_type;

   function automatic logic [31:0] atan_angle(input int idx);
      logic [31:0] tab [32];
      tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
              32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
              32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
              32'd166886, 32'd83443, 32'd41722, 32'd20861,
              32'd10430, 32'd5215, 32'd2608, 32'd1304,
              32'd652, 32'd326, 32'd163, 32'd81,
              32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
      return tab[idx & 31];
   endfunction

   // Squared CORDIC gain in Q30, worked out at elaboration.
   function automatic logic [63:0] gain_sq(input int stages);
      logic [63:0] k2;
      k2 = 64'd1 << 30;
      for (int i = 0; i < stages; i++) begin
         k2 = k2 + (k2 >> (2 * i));
      end
      return k2;
   endfunction

endpackage

// File: design/corner_track_extrapolator.sv
// Channel   Ports                         Handshake
// request   req_payload                   start high, busy low
// response  rsp_payload                   rsp_strobe, one cycle, no stall
// config    csr_gain                      csr_valid and csr_ready
//
// One item may enter every cycle; busy is always low. An item's result is
// transferred after it passes the two rows of CORDIC cells and five
// single-register stages. Reset clears the valid pipeline and restores
// step_gain to 192.
// The receiver cannot stall, so nothing in the pipeline ever holds.
`include "assert_macros.svh"
module corner_track_extrapolator #(
   parameter int CORDIC_STAGES = cte_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  cte_pkg::req_type                     req_payload,
   output logic                                 rsp_strobe,
   output cte_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cte_pkg::GAIN_WIDTH-1:0]       csr_gain
);
   localparam int VW = cte_pkg::VEC_WIDTH;
   localparam int LW = cte_pkg::LEN_WIDTH;
   // The extrapolated length fits in 28 signed bits for any pair of steps.
   localparam int SW = 28;
   localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int LAT = 2 * NS + 5;
   localparam logic [63:0] K2 = cte_pkg::gain_sq(NS);
   localparam logic [63:0] INV = (64'd1 << 62) / K2;

   logic [cte_pkg::GAIN_WIDTH-1:0] gain_ff;
   logic [LAT-1:0]                 vld_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= cte_pkg::GAIN_RESET;
         vld_ff  <= '0;
      end else begin
         if (csr_valid) begin
            gain_ff <= csr_gain;
         end
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   // Stage A: step vectors, zero flags and the half-turn pre-rotation.
   logic signed [VW-1:0] x1a_ff, y1a_ff, x2a_ff, y2a_ff;
   logic [31:0]          z1a_ff, z2a_ff;
   logic                 zero1_ff, zero2_ff;
   logic signed [15:0]   pxa_ff, pya_ff;
   logic signed [16:0]   d1x, d1y, d2x, d2y;

   always_comb begin
      d1x = 17'(req_payload.middle_x) - 17'(req_payload.first_x);
      d1y = 17'(req_payload.middle_y) - 17'(req_payload.first_y);
      d2x = 17'(req_payload.latest_x) - 17'(req_payload.middle_x);
      d2y = 17'(req_payload.latest_y) - 17'(req_payload.middle_y);
   end

   always_ff @(posedge clock) begin
      zero1_ff <= (d1x == 0) && (d1y == 0);
      zero2_ff <= (d2x == 0) && (d2y == 0);
      if (d1x < 0) begin
         x1a_ff <= -(VW'(d1x) <<< cte_pkg::GUARD);
         y1a_ff <= -(VW'(d1y) <<< cte_pkg::GUARD);
         z1a_ff <= 32'h8000_0000;
      end else begin
         x1a_ff <= VW'(d1x) <<< cte_pkg::GUARD;
         y1a_ff <= VW'(d1y) <<< cte_pkg::GUARD;
         z1a_ff <= '0;
      end
      if (d2x < 0) begin
         x2a_ff <= -(VW'(d2x) <<< cte_pkg::GUARD);
         y2a_ff <= -(VW'(d2y) <<< cte_pkg::GUARD);
         z2a_ff <= 32'h8000_0000;
      end else begin
         x2a_ff <= VW'(d2x) <<< cte_pkg::GUARD;
         y2a_ff <= VW'(d2y) <<< cte_pkg::GUARD;
         z2a_ff <= '0;
      end
      pxa_ff <= req_payload.latest_x;
      pya_ff <= req_payload.latest_y;
   end

   // Vectoring row; zero flags travel in a shift line alongside.
   logic signed [VW-1:0] vx1 [NS+1], vy1 [NS+1], vx2 [NS+1], vy2 [NS+1];
   logic [31:0]          vz1 [NS+1], vz2 [NS+1];
   logic signed [15:0]   vpx [NS+1], vpy [NS+1];
   logic [NS-1:0]        z1line_ff, z2line_ff;

   assign vx1[0] = x1a_ff;
   assign vy1[0] = y1a_ff;
   assign vz1[0] = z1a_ff;
   assign vx2[0] = x2a_ff;
   assign vy2[0] = y2a_ff;
   assign vz2[0] = z2a_ff;
   assign vpx[0] = pxa_ff;
   assign vpy[0] = pya_ff;

   always_ff @(posedge clock) begin
      z1line_ff <= {z1line_ff[NS-2:0], zero1_ff};
      z2line_ff <= {z2line_ff[NS-2:0], zero2_ff};
   end

   for (genvar i = 0; i < NS; i++) begin : g_vec
      cte_vec_cell #(.IDX(i)) u_cell (
         .clock (clock),
         .x1_in (vx1[i]), .y1_in (vy1[i]), .z1_in (vz1[i]),
         .x2_in (vx2[i]), .y2_in (vy2[i]), .z2_in (vz2[i]),
         .px_in (vpx[i]), .py_in (vpy[i]),
         .x1_ff (vx1[i+1]), .y1_ff (vy1[i+1]), .z1_ff (vz1[i+1]),
         .x2_ff (vx2[i+1]), .y2_ff (vy2[i+1]), .z2_ff (vz2[i+1]),
         .px_ff (vpx[i+1]), .py_ff (vpy[i+1])
      );
   end

   // Stage B: extrapolated angle and K-scaled length.
   logic [31:0]          a1, a2;
   logic signed [VW-1:0] m1, m2;
   logic [31:0]          a3b_ff;
   logic signed [SW-1:0] s3b_ff;
   logic signed [15:0]   pxb_ff, pyb_ff;

   always_comb begin
      a1 = z1line_ff[NS-1] ? 32'd0 : vz1[NS];
      a2 = z2line_ff[NS-1] ? 32'd0 : vz2[NS];
      m1 = z1line_ff[NS-1] ? '0 : vx1[NS];
      m2 = z2line_ff[NS-1] ? '0 : vx2[NS];
   end

   always_ff @(posedge clock) begin
      a3b_ff <= (a2 << 1) - a1;
      s3b_ff <= SW'((LW'(m2) <<< 1) - LW'(m1));
      pxb_ff <= vpx[NS];
      pyb_ff <= vpy[NS];
   end

   // Stage C: gain constant times step_gain. The product with the length is
   // split into two 16-bit halves of the constant, then combined in stage D.
   logic [63:0]            cgain;
   logic [15:0]            chi;
   logic [15:0]            clo;
   logic signed [SW+16:0]  prod_hi_ff;
   logic signed [SW+17:0]  prod_lo_ff;
   logic [31:0]            a3c_ff;
   logic signed [15:0]     pxc_ff, pyc_ff;

   always_comb begin
      cgain = (INV * 64'(gain_ff)) >> 8;
      chi   = 16'(cgain >> 16);
      clo   = cgain[15:0];
   end

   always_ff @(posedge clock) begin
      prod_hi_ff <= s3b_ff * $signed({1'b0, chi});
      prod_lo_ff <= s3b_ff * $signed({1'b0, clo}) + (SW+18)'(33'sh0_8000_0000);
      a3c_ff     <= a3b_ff;
      pxc_ff     <= pxb_ff;
      pyc_ff     <= pyb_ff;
   end

   // Stage D: start length and quadrant fold for the rotation row.
   logic signed [SW+17:0] sum_d;
   logic signed [LW-1:0]  s_d;
   logic [1:0]            quad;
   logic [31:0]           a_fold;
   logic signed [LW-1:0]  rx0_ff, ry0_ff;
   logic signed [32:0]    rz0_ff;
   logic signed [15:0]    pxd_ff, pyd_ff;

   always_comb begin
      sum_d  = (SW+18)'(prod_hi_ff) + (prod_lo_ff >>> 16);
      s_d    = LW'(sum_d >>> 16);
      quad   = a3c_ff[31:30];
      a_fold = (quad == 2'd1 || quad == 2'd2) ? a3c_ff + 32'h8000_0000 : a3c_ff;
   end

   always_ff @(posedge clock) begin
      rx0_ff <= (quad == 2'd1 || quad == 2'd2) ? -s_d : s_d;
      ry0_ff <= '0;
      rz0_ff <= $signed({a_fold[31], a_fold});
      pxd_ff <= pxc_ff;
      pyd_ff <= pyc_ff;
   end

   logic signed [LW-1:0] rx [NS+1], ry [NS+1];
   logic signed [32:0]   rz [NS+1];
   logic signed [15:0]   rpx [NS+1], rpy [NS+1];

   assign rx[0]  = rx0_ff;
   assign ry[0]  = ry0_ff;
   assign rz[0]  = rz0_ff;
   assign rpx[0] = pxd_ff;
   assign rpy[0] = pyd_ff;

   for (genvar i = 0; i < NS; i++) begin : g_rot
      cte_rot_cell #(.IDX(i)) u_cell (
         .clock (clock),
         .x_in  (rx[i]), .y_in (ry[i]), .z_in (rz[i]),
         .px_in (rpx[i]), .py_in (rpy[i]),
         .x_ff  (rx[i+1]), .y_ff (ry[i+1]), .z_ff (rz[i+1]),
         .px_ff (rpx[i+1]), .py_ff (rpy[i+1])
      );
   end

   // Stage E: rounding, offset from the newest point and saturation.
   logic signed [LW-1:0] ox, oy;
   logic signed [LW-1:0] hi_lim, lo_lim;
   logic                 cx_hi, cx_lo, cy_hi, cy_lo;
   cte_pkg::rsp_type     rsp_ff;

   always_comb begin
      hi_lim = LW'(32767);
      lo_lim = -LW'(32768);
      ox = LW'(rpx[NS]) + ((rx[NS] + LW'(1 << (cte_pkg::GUARD - 1))) >>> cte_pkg::GUARD);
      oy = LW'(rpy[NS]) + ((ry[NS] + LW'(1 << (cte_pkg::GUARD - 1))) >>> cte_pkg::GUARD);
      cx_hi = ox > hi_lim;
      cx_lo = ox < lo_lim;
      cy_hi = oy > hi_lim;
      cy_lo = oy < lo_lim;
   end

   always_ff @(posedge clock) begin
      rsp_ff.predicted_x <= cx_hi ? 16'sh7fff : cx_lo ? 16'sh8000 : ox[15:0];
      rsp_ff.predicted_y <= cy_hi ? 16'sh7fff : cy_lo ? 16'sh8000 : oy[15:0];
      rsp_ff.clipped     <= cx_hi | cx_lo | cy_hi | cy_lo;
   end

   assign rsp_strobe  = vld_ff[LAT-1];
   assign rsp_payload = rsp_ff;

   `ASSERT_NEXT(a_strobe_follows, clock, reset, start, vld_ff[0])
   `ASSERT_IMPLY(a_clip_flag, clock, reset,
      rsp_strobe && !rsp_payload.clipped,
      rsp_payload.predicted_x != 16'sh7fff || !rsp_payload.clipped)
   `ASSERT_NEXT(a_gain_write, clock, reset, csr_valid, gain_ff == $past(csr_gain))
endmodule

// File: design/cte_vec_cell.sv
// One vectoring CORDIC iteration for both steps, carrying the item alongside.
module cte_vec_cell #(
   parameter int IDX = 0
) (
   input  logic                                  clock,
   input  logic signed [cte_pkg::VEC_WIDTH-1:0]  x1_in,
   input  logic signed [cte_pkg::VEC_WIDTH-1:0]  y1_in,
   input  logic [31:0]                           z1_in,
   input  logic signed [cte_pkg::VEC_WIDTH-1:0]  x2_in,
   input  logic signed [cte_pkg::VEC_WIDTH-1:0]  y2_in,
   input  logic [31:0]                           z2_in,
   input  logic signed [15:0]                    px_in,
   input  logic signed [15:0]                    py_in,
   output logic signed [cte_pkg::VEC_WIDTH-1:0]  x1_ff,
   output logic signed [cte_pkg::VEC_WIDTH-1:0]  y1_ff,
   output logic [31:0]                           z1_ff,
   output logic signed [cte_pkg::VEC_WIDTH-1:0]  x2_ff,
   output logic signed [cte_pkg::VEC_WIDTH-1:0]  y2_ff,
   output logic [31:0]                           z2_ff,
   output logic signed [15:0]                    px_ff,
   output logic signed [15:0]                    py_ff
);
   localparam logic [31:0] ATAN = cte_pkg::atan_angle(IDX);

   always_ff @(posedge clock) begin
      if (y1_in >= 0) begin
         x1_ff <= x1_in + (y1_in >>> IDX);
         y1_ff <= y1_in - (x1_in >>> IDX);
         z1_ff <= z1_in + ATAN;
      end else begin
         x1_ff <= x1_in - (y1_in >>> IDX);
         y1_ff <= y1_in + (x1_in >>> IDX);
         z1_ff <= z1_in - ATAN;
      end
      if (y2_in >= 0) begin
         x2_ff <= x2_in + (y2_in >>> IDX);
         y2_ff <= y2_in - (x2_in >>> IDX);
         z2_ff <= z2_in + ATAN;
      end else begin
         x2_ff <= x2_in - (y2_in >>> IDX);
         y2_ff <= y2_in + (x2_in >>> IDX);
         z2_ff <= z2_in - ATAN;
      end
      px_ff <= px_in;
      py_ff <= py_in;
   end
endmodule

// File: design/cte_rot_cell.sv
// One rotation CORDIC iteration, carrying the newest point alongside.
module cte_rot_cell #(
   parameter int IDX = 0
) (
   input  logic                                  clock,
   input  logic signed [cte_pkg::LEN_WIDTH-1:0]  x_in,
   input  logic signed [cte_pkg::LEN_WIDTH-1:0]  y_in,
   input  logic signed [32:0]                    z_in,
   input  logic signed [15:0]                    px_in,
   input  logic signed [15:0]                    py_in,
   output logic signed [cte_pkg::LEN_WIDTH-1:0]  x_ff,
   output logic signed [cte_pkg::LEN_WIDTH-1:0]  y_ff,
   output logic signed [32:0]                    z_ff,
   output logic signed [15:0]                    px_ff,
   output logic signed [15:0]                    py_ff
);
   localparam logic signed [32:0] ATAN = {1'b0, cte_pkg::atan_angle(IDX)};

   always_ff @(posedge clock) begin
      if (z_in >= 0) begin
         x_ff <= x_in - (y_in >>> IDX);
         y_ff <= y_in + (x_in >>> IDX);
         z_ff <= z_in - ATAN;
      end else begin
         x_ff <= x_in + (y_in >>> IDX);
         y_ff <= y_in - (x_in >>> IDX);
         z_ff <= z_in + ATAN;
      end
      px_ff <= px_in;
      py_ff <= py_in;
   end
endmodule
